### src/frc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the frame relay controller.
// No dependencies; every other file in src uses it.
package frc_pkg;

    // Frame bytes
    localparam logic [7:0] DELIM      = 8'h7E;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [7:0] REPLY_LEN  = 8'h0F;
    localparam logic [7:0] FRAME_ID   = 8'h01;
    localparam logic [7:0] NET16_HI   = 8'hFF;
    localparam logic [7:0] NET16_LO   = 8'hFE;
    localparam logic [7:0] SUM_GOOD   = 8'hFF;

    // Byte positions inside a received frame (delimiter at 0)
    localparam int POS_LEN_HI    = 1;
    localparam int POS_LEN_LO    = 2;
    localparam int POS_TYPE      = 3;
    localparam int POS_SRC_FIRST = 4;
    localparam int POS_SRC_LAST  = 11;
    localparam int POS_CMD       = 15;

    // Length thresholds
    localparam logic [15:0] LEARN_LEN = 16'd9;
    localparam logic [15:0] CMD_LEN   = 16'd13;
    localparam logic [16:0] LEN_EXTRA = 17'd4;

    // Reply burst
    localparam int REPLY_BYTES = 19;
    localparam int BEAT_W      = 5;

    // Event codes
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_CMD      = 3'd1;
    localparam logic [2:0] EV_UNKNOWN  = 3'd2;
    localparam logic [2:0] EV_BADSUM   = 3'd3;
    localparam logic [2:0] EV_OVERFLOW = 3'd4;

    // Register indexes
    localparam int         CFG_IDX_W   = 3;
    localparam logic [2:0] CFG_RX_TYPE = 3'd0;
    localparam logic [2:0] CFG_TX_TYPE = 3'd1;
    localparam logic [2:0] CFG_ON      = 3'd2;
    localparam logic [2:0] CFG_OFF     = 3'd3;
    localparam logic [2:0] CFG_TOGGLE  = 3'd4;
    localparam logic [2:0] CFG_POLL    = 3'd5;

    // Frame summary kinds passed from front to back
    localparam logic [2:0] KIND_OVF     = 3'd0;
    localparam logic [2:0] KIND_BADSUM  = 3'd1;
    localparam logic [2:0] KIND_NOACT   = 3'd2;
    localparam logic [2:0] KIND_LEARN   = 3'd3;
    localparam logic [2:0] KIND_UNKNOWN = 3'd4;
    localparam logic [2:0] KIND_CMD     = 3'd5;

    // Relay operations
    localparam logic [1:0] OP_ON     = 2'd0;
    localparam logic [1:0] OP_OFF    = 2'd1;
    localparam logic [1:0] OP_TOGGLE = 2'd2;
    localparam logic [1:0] OP_POLL   = 2'd3;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] rx_type;
        logic [7:0] tx_type;
        logic [7:0] on_code;
        logic [7:0] off_code;
        logic [7:0] toggle_code;
        logic [7:0] poll_code;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  op;
        logic [63:0] src;
    } t_job;

endpackage

### src/frc_if.sv
`timescale 1ns / 1ps
// Channel interfaces: received bytes, results and register writes.
// Depends on frc_pkg for the register index width.
interface frc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface frc_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       relay_on;
    logic       peer_known;

    modport source (output valid, output event_res, output tx_valid, output tx_byte,
                    output tx_last, output relay_on, output peer_known, input ready);
    modport sink   (input valid, input event_res, input tx_valid, input tx_byte,
                    input tx_last, input relay_on, input peer_known, output ready);
endinterface

interface frc_cfg_if;
    logic [frc_pkg::CFG_IDX_W-1:0] index;
    logic                          valid;
    logic                          ready;
    logic [7:0]                    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/frc_front.sv
`timescale 1ns / 1ps
// Receive framer: collects frame fields byte by byte and classifies each
// finished or overflowed frame into a job. Depends on frc_pkg, frc_if.
module frc_front #(
    parameter int BUFFER_BYTES = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  frc_pkg::t_cfg i_cfg,
    frc_byte_if.sink      i_rx,
    output logic          o_job_valid,
    output frc_pkg::t_job o_job,
    input  logic          i_job_ready
);
    import frc_pkg::*;

    localparam int IDX_W = $clog2(BUFFER_BYTES + 1);

    logic             r_in_frame, n_in_frame;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [15:0]      r_len, n_len;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_type, n_type;
    logic [63:0]      r_src, n_src;
    logic [7:0]       r_cmd, n_cmd;
    logic             w_accept, w_end, w_ovf, w_unknown;
    logic [1:0]       w_op;
    logic [2:0]       w_kind;

    assign i_rx.ready = i_job_ready;
    assign w_accept   = i_rx.valid && i_rx.ready;

    always_comb begin
        n_in_frame = r_in_frame;
        n_idx      = r_idx;
        n_len      = r_len;
        n_sum      = r_sum;
        n_type     = r_type;
        n_src      = r_src;
        n_cmd      = r_cmd;
        w_end      = 1'b0;
        w_ovf      = 1'b0;
        if (w_accept) begin
            if (!r_in_frame) begin
                if (i_rx.rx_byte == DELIM) begin
                    n_in_frame = 1'b1;
                    n_idx      = IDX_W'(1);
                    n_len      = '0;
                    n_sum      = '0;
                    n_type     = '0;
                    n_src      = '0;
                    n_cmd      = '0;
                end
            end else begin
                n_idx = r_idx + IDX_W'(1);
                if (r_idx == IDX_W'(POS_LEN_HI)) begin
                    n_len = {i_rx.rx_byte, 8'h00};
                end else if (r_idx == IDX_W'(POS_LEN_LO)) begin
                    n_len = {r_len[15:8], i_rx.rx_byte};
                end else begin
                    n_sum = r_sum + i_rx.rx_byte;
                    if (r_idx == IDX_W'(POS_TYPE)) begin
                        n_type = i_rx.rx_byte;
                    end else if (r_idx >= IDX_W'(POS_SRC_FIRST) &&
                                 r_idx <= IDX_W'(POS_SRC_LAST)) begin
                        n_src = {r_src[55:0], i_rx.rx_byte};
                    end else if (r_idx == IDX_W'(POS_CMD)) begin
                        n_cmd = i_rx.rx_byte;
                    end
                end
                // frame end wins over overflow on the same byte
                if (n_len != '0 && 17'(n_idx) == 17'(n_len) + LEN_EXTRA) begin
                    w_end = 1'b1;
                end else if (n_idx == IDX_W'(BUFFER_BYTES)) begin
                    w_ovf = 1'b1;
                end
                if (w_end || w_ovf) begin
                    n_in_frame = 1'b0;
                    n_idx      = '0;
                    n_len      = '0;
                end
            end
        end
    end

    // command decode, first match wins
    always_comb begin
        w_unknown = 1'b0;
        if (n_cmd == i_cfg.on_code) begin
            w_op = OP_ON;
        end else if (n_cmd == i_cfg.off_code) begin
            w_op = OP_OFF;
        end else if (n_cmd == i_cfg.toggle_code) begin
            w_op = OP_TOGGLE;
        end else begin
            w_op      = OP_POLL;
            w_unknown = (n_cmd != i_cfg.poll_code);
        end
    end

    // length as held before end_frame clears it
    logic [15:0] w_held_len;
    always_comb begin
        w_held_len = (r_idx == IDX_W'(POS_LEN_LO)) ? {r_len[15:8], i_rx.rx_byte} : r_len;
        if (w_ovf) begin
            w_kind = KIND_OVF;
        end else if (n_sum != SUM_GOOD) begin
            w_kind = KIND_BADSUM;
        end else if (n_type != i_cfg.rx_type || w_held_len < LEARN_LEN) begin
            w_kind = KIND_NOACT;
        end else if (w_held_len < CMD_LEN) begin
            w_kind = KIND_LEARN;
        end else if (w_unknown) begin
            w_kind = KIND_UNKNOWN;
        end else begin
            w_kind = KIND_CMD;
        end
    end

    assign o_job_valid = w_accept && (w_end || w_ovf);
    assign o_job.kind  = w_kind;
    assign o_job.op    = w_op;
    assign o_job.src   = n_src;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_idx      <= '0;
            r_len      <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_idx      <= n_idx;
            r_len      <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_type <= n_type;
        r_src  <= n_src;
        r_cmd  <= n_cmd;
    end

endmodule

### src/frc_queue.sv
`timescale 1ns / 1ps
// Two-entry job queue between the framer and the reply engine.
// Depends on frc_pkg.
module frc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  frc_pkg::t_job i_job,
    output logic          o_not_full,
    output logic          o_valid,
    output frc_pkg::t_job o_job,
    input  logic          i_pop
);
    import frc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_not_full = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid    = (r_count != '0);
    assign o_job      = r_mem[r_rd_ptr];
    assign w_push     = i_push && o_not_full;
    assign w_pop      = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

### src/frc_back.sv
`timescale 1ns / 1ps
// Reply engine: applies each job to the relay and peer state and drives
// the result register, including the 19-byte reply burst. Needs frc_pkg, frc_if.
module frc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  frc_pkg::t_cfg i_cfg,
    input  logic          i_job_valid,
    input  frc_pkg::t_job i_job,
    output logic          o_job_pop,
    frc_res_if.source     o_res
);
    import frc_pkg::*;

    logic              r_relay, n_relay;
    logic              r_peer, n_peer;
    logic [63:0]       r_addr, n_addr;
    logic              r_busy, n_busy;
    logic [BEAT_W-1:0] r_beat, n_beat;
    logic [7:0]        r_csum, n_csum;
    logic              r_out_valid, n_out_valid;
    logic [2:0]        r_ev, n_ev;
    logic              r_txv, n_txv;
    logic [7:0]        r_byte, n_byte;
    logic              r_last, n_last;
    logic              w_load;
    logic [7:0]        w_beat_byte;

    // reply byte for the current beat
    always_comb begin
        case (r_beat)
            5'd0:    w_beat_byte = DELIM;
            5'd1:    w_beat_byte = ZERO_BYTE;
            5'd2:    w_beat_byte = REPLY_LEN;
            5'd3:    w_beat_byte = i_cfg.tx_type;
            5'd4:    w_beat_byte = FRAME_ID;
            5'd5:    w_beat_byte = r_addr[63:56];
            5'd6:    w_beat_byte = r_addr[55:48];
            5'd7:    w_beat_byte = r_addr[47:40];
            5'd8:    w_beat_byte = r_addr[39:32];
            5'd9:    w_beat_byte = r_addr[31:24];
            5'd10:   w_beat_byte = r_addr[23:16];
            5'd11:   w_beat_byte = r_addr[15:8];
            5'd12:   w_beat_byte = r_addr[7:0];
            5'd13:   w_beat_byte = NET16_HI;
            5'd14:   w_beat_byte = NET16_LO;
            5'd15:   w_beat_byte = ZERO_BYTE;
            5'd16:   w_beat_byte = ZERO_BYTE;
            5'd17:   w_beat_byte = r_relay ? i_cfg.on_code : i_cfg.off_code;
            default: w_beat_byte = SUM_GOOD - r_csum;
        endcase
    end

    assign w_load = !r_out_valid || o_res.ready;

    always_comb begin
        n_relay     = r_relay;
        n_peer      = r_peer;
        n_addr      = r_addr;
        n_busy      = r_busy;
        n_beat      = r_beat;
        n_csum      = r_csum;
        n_out_valid = r_out_valid;
        n_ev        = r_ev;
        n_txv       = r_txv;
        n_byte      = r_byte;
        n_last      = r_last;
        o_job_pop   = 1'b0;
        if (w_load) begin
            if (r_busy) begin
                n_out_valid = 1'b1;
                n_ev        = EV_CMD;
                n_txv       = 1'b1;
                n_byte      = w_beat_byte;
                n_last      = (r_beat == BEAT_W'(REPLY_BYTES - 1));
                if (r_beat >= BEAT_W'(3) && r_beat <= BEAT_W'(REPLY_BYTES - 2)) begin
                    n_csum = r_csum + w_beat_byte;
                end
                n_beat = r_beat + BEAT_W'(1);
                if (n_last) begin
                    n_busy = 1'b0;
                end
            end else if (i_job_valid) begin
                o_job_pop   = 1'b1;
                n_out_valid = 1'b1;
                n_txv       = 1'b0;
                n_byte      = ZERO_BYTE;
                n_last      = 1'b1;
                if ((i_job.kind == KIND_LEARN || i_job.kind == KIND_UNKNOWN ||
                     i_job.kind == KIND_CMD) && !r_peer) begin
                    n_peer = 1'b1;
                    n_addr = i_job.src;
                end
                unique case (i_job.kind)
                    KIND_OVF:     n_ev = EV_OVERFLOW;
                    KIND_BADSUM:  n_ev = EV_BADSUM;
                    KIND_UNKNOWN: n_ev = EV_UNKNOWN;
                    KIND_CMD: begin
                        n_ev = EV_CMD;
                        unique case (i_job.op)
                            OP_ON:     n_relay = 1'b1;
                            OP_OFF:    n_relay = 1'b0;
                            OP_TOGGLE: n_relay = !r_relay;
                            default:   n_relay = r_relay;
                        endcase
                        if (n_peer) begin
                            // open the reply burst with the delimiter
                            n_txv  = 1'b1;
                            n_byte = DELIM;
                            n_last = 1'b0;
                            n_busy = 1'b1;
                            n_beat = BEAT_W'(1);
                            n_csum = '0;
                        end
                    end
                    default:      n_ev = EV_NONE;
                endcase
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay     <= 1'b0;
            r_peer      <= 1'b0;
            r_busy      <= 1'b0;
            r_beat      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_relay     <= n_relay;
            r_peer      <= n_peer;
            r_busy      <= n_busy;
            r_beat      <= n_beat;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_csum <= n_csum;
        r_ev   <= n_ev;
        r_txv  <= n_txv;
        r_byte <= n_byte;
        r_last <= n_last;
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.event_res  = r_ev;
    assign o_res.tx_valid   = r_txv;
    assign o_res.tx_byte    = r_byte;
    assign o_res.tx_last    = r_last;
    assign o_res.relay_on   = r_relay;
    assign o_res.peer_known = r_peer;

endmodule

### src/api_frame_relay_controller_top.sv
`timescale 1ns / 1ps
// Top level of the frame relay controller: register file and assembly of
// framer, job queue and reply engine. Depends on frc_pkg, frc_if and submodules.
//
// Usage:
//   i_rx  : one received serial byte per transfer. A byte is taken every cycle
//           as long as the two-entry job queue has room.
//   o_res : result items. A byte that ends or overflows a frame gives one
//           item with tx_valid low, or 19 items carrying the reply frame when
//           a command is applied; all other bytes give nothing.
//   i_cfg : register writes (index, data), always ready; indexes beyond the
//           six registers are dropped. Write only while the block is idle.
// Throughput: one byte per cycle in while the queue has room; one result per
// cycle out while o_res is ready. A reply holds the result register for all
// its 19 items, so frame ends arriving faster fill the queue and input waits.
// The ending byte's job is written into the queue; once it reaches the head,
// the reply engine loads the first result into the result register.
// Reset (synchronous, active low) clears framing, relay, learned peer,
// queue and output; registers return to their documented defaults.
// When o_res stalls, the result register holds and the queue absorbs up to
// two finished frames before i_rx.ready drops.
module api_frame_relay_controller_top #(
    parameter int BUFFER_BYTES = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    frc_byte_if.sink  i_rx,
    frc_res_if.source o_res,
    frc_cfg_if.sink   i_cfg
);
    import frc_pkg::*;

    t_cfg r_cfg;
    logic w_job_valid, w_q_not_full, w_q_valid, w_pop;
    t_job w_job, w_q_job;

    // register file: writes always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rx_type     <= 8'd144;
            r_cfg.tx_type     <= 8'd16;
            r_cfg.on_code     <= 8'd1;
            r_cfg.off_code    <= 8'd0;
            r_cfg.toggle_code <= 8'd2;
            r_cfg.poll_code   <= 8'd3;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_RX_TYPE: r_cfg.rx_type     <= i_cfg.data;
                CFG_TX_TYPE: r_cfg.tx_type     <= i_cfg.data;
                CFG_ON:      r_cfg.on_code     <= i_cfg.data;
                CFG_OFF:     r_cfg.off_code    <= i_cfg.data;
                CFG_TOGGLE:  r_cfg.toggle_code <= i_cfg.data;
                CFG_POLL:    r_cfg.poll_code   <= i_cfg.data;
                default:     ;
            endcase
        end
    end

    // front: framing and classification
    frc_front #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_rx        (i_rx),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_ready (w_q_not_full)
    );

    // decoupling queue
    frc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_job_valid),
        .i_job      (w_job),
        .o_not_full (w_q_not_full),
        .o_valid    (w_q_valid),
        .o_job      (w_q_job),
        .i_pop      (w_pop)
    );

    // back: relay state and reply generation
    frc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (w_q_valid),
        .i_job       (w_q_job),
        .o_job_pop   (w_pop),
        .o_res       (o_res)
    );

    // reply bytes only ever belong to an applied command
    a_tx_is_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.tx_valid |-> o_res.event_res == EV_CMD)
        else $error("reply byte with wrong event");

    // a result without a reply byte is always the only one for its frame
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.tx_valid |-> o_res.tx_last)
        else $error("non-reply result not marked last");

    // a reply is only sent to a learned peer
    a_tx_peer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.tx_valid |-> o_res.peer_known)
        else $error("reply sent without a learned peer");

    // a learned peer is never forgotten
    a_peer_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.peer_known |=> o_res.peer_known)
        else $error("peer address lost");

endmodule
